FILE: sv/mfba_pkg.sv
package mfba_pkg;

  localparam int MAX_VERTICES = 128;
  localparam int MAX_EDGES    = 1024;
  localparam int SLOT_COUNT   = 2 * MAX_EDGES;
  localparam int VID_W        = 7;
  localparam int CNT_W        = 8;
  localparam int EDGE_W       = 10;
  localparam int SLOT_W       = 11;
  localparam int CAP_W        = 32;
  localparam int RES_W        = 48;

  localparam logic [CAP_W-1:0] CAP_ALL_ONES = '1;
  localparam logic [RES_W-1:0] RESULT_MAX   = '1;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_SOLVE  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ADD0, ST_ADD1, ST_ADD2, ST_ADD3, ST_RD0,
    ST_INIT, ST_POP, ST_U, ST_U2, ST_SL,
    ST_A0, ST_A1, ST_AV, ST_AP, ST_AQ, ST_AR, ST_ATOT, ST_DONE
  } state_t;

endpackage

FILE: sv/mfba_ram.sv
module mfba_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] wa,
  input  logic [W-1:0]         wd,
  input  logic [$clog2(D)-1:0] ra,
  output logic [W-1:0]         rd
);

  logic [W-1:0] mem [D];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

FILE: sv/max_flow_bfs_augment.sv
// Edmonds-Karp max flow engine.
// Input channel (in_valid/in_ready) takes one word: a mode plus its fields.
//   Mode 0 appends an edge (forward and reverse slot), mode 1 solves max flow
//   from in_vertex_a to in_vertex_b, mode 2 reads one edge's flow.
// Result channel (out_valid/out_ready) returns one word per input word:
//   out_result_value and out_status (ok, table full, bad vertex/index/mode).
// Config channel (cfg_valid/cfg_ready) writes vertex_count; write it only
//   while the block is idle.
// Steps: an add writes the forward and reverse slots, then links each onto its
//   vertex list; a read does one flow lookup. A solve runs one BFS pass per
//   augmenting path, scanning each dequeued vertex's slots, then walks the path
//   back to augment; all steps go through one sequencer, and each slot memory
//   has one write and one read port. One word is in work at a time; in_ready is
//   high only while idle. A finished result sits in an output register; if the
//   receiver stalls the sequencer holds the next result until that register frees up.
// Reset (synchronous, rst_n low) empties the edge table, clears the vertex
//   list flags and sets vertex_count to 128. Memory contents are not cleared;
//   nothing is read before it is written.
module max_flow_bfs_augment (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_mode,
  input  logic [mfba_pkg::VID_W-1:0]  in_vertex_a,
  input  logic [mfba_pkg::VID_W-1:0]  in_vertex_b,
  input  logic [mfba_pkg::CAP_W-1:0]  in_capacity,
  input  logic [mfba_pkg::EDGE_W-1:0] in_edge_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mfba_pkg::RES_W-1:0]  out_result_value,
  output logic [1:0]                  out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_data
);
  import mfba_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0]              vcount_r;
  logic [CNT_W-1:0]        n_w;
  logic [VID_W-1:0]        a_r, b_r, v_r, v_nxt;
  logic [CAP_W-1:0]        cap_r;
  logic [SLOT_W-1:0]       ecnt_r, ecnt_nxt;
  logic [MAX_VERTICES-1:0] has_r, has_nxt, vis_r, vis_nxt;
  logic [CNT_W-1:0]        qh_r, qh_nxt, qt_r, qt_nxt;
  logic [SLOT_W-1:0]       sl_r, sl_nxt, ulast_r, ulast_nxt;
  logic [SLOT_W-1:0]       pa_r, pa_nxt, pb_r, pb_nxt;
  logic [CAP_W-1:0]        ubot_r, ubot_nxt, f_r, f_nxt;
  logic [RES_W-1:0]        total_r, total_nxt, rval_r, rval_nxt;
  logic [1:0]              rst_r, rst_nxt;
  logic                    ov_r;
  logic [RES_W-1:0]        oval_r;
  logic [1:0]              ost_r;

  // memory ports
  logic                    hd_we, rs_we, nx_we, fl_we, vf_we, vl_we, pr_we, bt_we, qu_we;
  logic [SLOT_W-1:0]       hd_wa, hd_ra, rs_wa, rs_ra, nx_wa, nx_ra;
  logic [EDGE_W-1:0]       fl_wa, fl_ra;
  logic [VID_W-1:0]        vf_wa, vf_ra, vl_wa, vl_ra, pr_wa, pr_ra, bt_wa, bt_ra;
  logic [VID_W-1:0]        qu_wa, qu_ra;
  logic [VID_W-1:0]        hd_wd, hd_rd, qu_wd, qu_rd;
  logic [CAP_W-1:0]        rs_wd, rs_rd, fl_wd, fl_rd, bt_wd, bt_rd;
  logic [SLOT_W-1:0]       nx_wd, nx_rd, vf_wd, vf_rd, vl_wd, vl_rd, pr_wd, pr_rd;

  logic                    acc;
  logic                    bad_a, bad_b;
  logic [SLOT_W-1:0]       fw_w, bw_w, prev_b_w;
  logic                    take_w;
  logic [CAP_W-1:0]        min_w;
  logic                    out_free;

  mfba_ram #(.W(VID_W),  .D(SLOT_COUNT))   u_head (.clk, .we(hd_we), .wa(hd_wa), .wd(hd_wd),
                                                   .ra(hd_ra), .rd(hd_rd));
  mfba_ram #(.W(CAP_W),  .D(SLOT_COUNT))   u_res  (.clk, .we(rs_we), .wa(rs_wa), .wd(rs_wd),
                                                   .ra(rs_ra), .rd(rs_rd));
  mfba_ram #(.W(SLOT_W), .D(SLOT_COUNT))   u_next (.clk, .we(nx_we), .wa(nx_wa), .wd(nx_wd),
                                                   .ra(nx_ra), .rd(nx_rd));
  mfba_ram #(.W(CAP_W),  .D(MAX_EDGES))    u_flow (.clk, .we(fl_we), .wa(fl_wa), .wd(fl_wd),
                                                   .ra(fl_ra), .rd(fl_rd));
  mfba_ram #(.W(SLOT_W), .D(MAX_VERTICES)) u_vfst (.clk, .we(vf_we), .wa(vf_wa), .wd(vf_wd),
                                                   .ra(vf_ra), .rd(vf_rd));
  mfba_ram #(.W(SLOT_W), .D(MAX_VERTICES)) u_vlst (.clk, .we(vl_we), .wa(vl_wa), .wd(vl_wd),
                                                   .ra(vl_ra), .rd(vl_rd));
  mfba_ram #(.W(SLOT_W), .D(MAX_VERTICES)) u_par  (.clk, .we(pr_we), .wa(pr_wa), .wd(pr_wd),
                                                   .ra(pr_ra), .rd(pr_rd));
  mfba_ram #(.W(CAP_W),  .D(MAX_VERTICES)) u_bot  (.clk, .we(bt_we), .wa(bt_wa), .wd(bt_wd),
                                                   .ra(bt_ra), .rd(bt_rd));
  mfba_ram #(.W(VID_W),  .D(MAX_VERTICES)) u_que  (.clk, .we(qu_we), .wa(qu_wa), .wd(qu_wd),
                                                   .ra(qu_ra), .rd(qu_rd));

  // effective vertex count, clamped to 1..MAX_VERTICES
  always_comb begin
    if (vcount_r == 8'd0) begin
      n_w = CNT_W'(1);
    end else if (32'(vcount_r) > MAX_VERTICES) begin
      n_w = CNT_W'(MAX_VERTICES);
    end else begin
      n_w = CNT_W'(vcount_r);
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;
  assign bad_a     = {1'b0, in_vertex_a} >= n_w;
  assign bad_b     = {1'b0, in_vertex_b} >= n_w;
  assign fw_w      = {ecnt_r[EDGE_W-1:0], 1'b0};
  assign bw_w      = {ecnt_r[EDGE_W-1:0], 1'b1};
  assign prev_b_w  = (a_r == b_r) ? fw_w : pb_r;
  assign out_free  = !ov_r || out_ready;
  // slot scan: take a fresh neighbor over a slot with residual left
  assign take_w    = ({1'b0, hd_rd} < n_w) && !vis_r[hd_rd] && (rs_rd != '0);
  assign min_w     = (rs_rd < ubot_r) ? rs_rd : ubot_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_mode)
            MODE_ADD: begin
              state_nxt = (bad_a || bad_b || 32'(ecnt_r) >= MAX_EDGES) ? ST_DONE : ST_ADD0;
            end
            MODE_SOLVE: begin
              state_nxt = (bad_a || bad_b || in_vertex_a == in_vertex_b) ? ST_DONE : ST_INIT;
            end
            MODE_READ: begin
              state_nxt = ({1'b0, in_edge_index} >= ecnt_r) ? ST_DONE : ST_RD0;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ADD0: state_nxt = ST_ADD1;
      ST_ADD1: state_nxt = ST_ADD2;
      ST_ADD2: state_nxt = ST_ADD3;
      ST_ADD3: state_nxt = ST_DONE;
      ST_RD0:  state_nxt = ST_DONE;
      ST_INIT: state_nxt = ST_POP;
      ST_POP: begin
        if (vis_r[b_r]) begin
          state_nxt = ST_A0;
        end else if (qh_r < qt_r) begin
          state_nxt = ST_U;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_U:    state_nxt = has_r[qu_rd] ? ST_U2 : ST_POP;
      ST_U2:   state_nxt = ST_SL;
      ST_SL:   state_nxt = (sl_r == ulast_r) ? ST_POP : ST_SL;
      ST_A0:   state_nxt = ST_A1;
      ST_A1:   state_nxt = ST_AV;
      ST_AV:   state_nxt = (v_r == a_r) ? ST_ATOT : ST_AP;
      ST_AP:   state_nxt = ST_AQ;
      ST_AQ:   state_nxt = ST_AR;
      ST_AR:   state_nxt = ST_AV;
      ST_ATOT: state_nxt = ST_INIT;
      ST_DONE: state_nxt = out_free ? ST_IDLE : ST_DONE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
    rs_we = 1'b0; rs_wa = '0; rs_wd = '0; rs_ra = '0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
    fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
    vf_we = 1'b0; vf_wa = '0; vf_wd = '0; vf_ra = '0;
    vl_we = 1'b0; vl_wa = '0; vl_wd = '0; vl_ra = '0;
    pr_we = 1'b0; pr_wa = '0; pr_wd = '0; pr_ra = '0;
    bt_we = 1'b0; bt_wa = '0; bt_wd = '0; bt_ra = '0;
    qu_we = 1'b0; qu_wa = '0; qu_wd = '0; qu_ra = '0;
    ecnt_nxt  = ecnt_r;
    has_nxt   = has_r;
    vis_nxt   = vis_r;
    qh_nxt    = qh_r;
    qt_nxt    = qt_r;
    sl_nxt    = sl_r;
    ulast_nxt = ulast_r;
    ubot_nxt  = ubot_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    f_nxt     = f_r;
    v_nxt     = v_r;
    total_nxt = total_r;
    rval_nxt  = rval_r;
    rst_nxt   = rst_r;
    case (state_r)
      ST_IDLE: begin
        vl_ra = in_vertex_a;
        fl_ra = in_edge_index;
        total_nxt = '0;
        rval_nxt  = '0;
        rst_nxt   = STAT_OK;
        if (acc) begin
          case (in_mode)
            MODE_ADD: begin
              if (bad_a || bad_b) begin
                rst_nxt = STAT_BAD;
              end else if (32'(ecnt_r) >= MAX_EDGES) begin
                rst_nxt = STAT_FULL;
              end
            end
            MODE_SOLVE: begin
              if (bad_a || bad_b || in_vertex_a == in_vertex_b) begin
                rst_nxt = STAT_BAD;
              end
            end
            MODE_READ: begin
              if ({1'b0, in_edge_index} >= ecnt_r) begin
                rst_nxt = STAT_BAD;
              end
            end
            default: rst_nxt = STAT_BAD;
          endcase
        end
      end
      // forward slot and edge flow
      ST_ADD0: begin
        hd_we = 1'b1; hd_wa = fw_w; hd_wd = b_r;
        rs_we = 1'b1; rs_wa = fw_w; rs_wd = cap_r;
        nx_we = 1'b1; nx_wa = fw_w; nx_wd = '0;
        fl_we = 1'b1; fl_wa = ecnt_r[EDGE_W-1:0]; fl_wd = '0;
        vl_ra = b_r;
        pa_nxt = vl_rd;
      end
      // reverse slot
      ST_ADD1: begin
        hd_we = 1'b1; hd_wa = bw_w; hd_wd = a_r;
        rs_we = 1'b1; rs_wa = bw_w; rs_wd = '0;
        nx_we = 1'b1; nx_wa = bw_w; nx_wd = '0;
        pb_nxt = vl_rd;
      end
      // link forward slot onto the tail's list
      ST_ADD2: begin
        if (has_r[a_r]) begin
          nx_we = 1'b1; nx_wa = pa_r; nx_wd = fw_w;
        end else begin
          vf_we = 1'b1; vf_wa = a_r; vf_wd = fw_w;
        end
        vl_we = 1'b1; vl_wa = a_r; vl_wd = fw_w;
        has_nxt[a_r] = 1'b1;
      end
      // link reverse slot onto the head's list
      ST_ADD3: begin
        if (has_r[b_r]) begin
          nx_we = 1'b1; nx_wa = prev_b_w; nx_wd = bw_w;
        end else begin
          vf_we = 1'b1; vf_wa = b_r; vf_wd = bw_w;
        end
        vl_we = 1'b1; vl_wa = b_r; vl_wd = bw_w;
        has_nxt[b_r] = 1'b1;
        ecnt_nxt = ecnt_r + 1'b1;
      end
      ST_RD0: begin
        rval_nxt = RES_W'(fl_rd);
      end
      // start a search from the source
      ST_INIT: begin
        vis_nxt = '0;
        vis_nxt[a_r] = 1'b1;
        bt_we = 1'b1; bt_wa = a_r; bt_wd = CAP_ALL_ONES;
        qu_we = 1'b1; qu_wa = '0; qu_wd = a_r;
        qh_nxt = '0;
        qt_nxt = CNT_W'(1);
      end
      ST_POP: begin
        qu_ra = qh_r[VID_W-1:0];
        if (!vis_r[b_r] && qh_r < qt_r) begin
          qh_nxt = qh_r + 1'b1;
        end
        if (!vis_r[b_r] && !(qh_r < qt_r)) begin
          rval_nxt = total_r;
        end
      end
      ST_U: begin
        vf_ra = qu_rd;
        vl_ra = qu_rd;
        bt_ra = qu_rd;
      end
      ST_U2: begin
        sl_nxt    = vf_rd;
        ulast_nxt = vl_rd;
        ubot_nxt  = bt_rd;
        hd_ra = vf_rd;
        rs_ra = vf_rd;
        nx_ra = vf_rd;
      end
      // one slot per cycle; reads for the next slot go out now
      ST_SL: begin
        if (take_w) begin
          vis_nxt[hd_rd] = 1'b1;
          pr_we = 1'b1; pr_wa = hd_rd; pr_wd = sl_r;
          bt_we = 1'b1; bt_wa = hd_rd; bt_wd = min_w;
          if (32'(qt_r) < MAX_VERTICES) begin
            qu_we = 1'b1; qu_wa = qt_r[VID_W-1:0]; qu_wd = hd_rd;
            qt_nxt = qt_r + 1'b1;
          end
        end
        sl_nxt = nx_rd;
        hd_ra = nx_rd;
        rs_ra = nx_rd;
        nx_ra = nx_rd;
      end
      ST_A0: begin
        bt_ra = b_r;
      end
      ST_A1: begin
        f_nxt = bt_rd;
        v_nxt = b_r;
      end
      ST_AV: begin
        pr_ra = v_r;
      end
      ST_AP: begin
        sl_nxt = pr_rd;
        rs_ra = pr_rd;
        fl_ra = pr_rd[SLOT_W-1:1];
      end
      // push along the slot, and lower or raise the edge flow
      ST_AQ: begin
        rs_we = 1'b1; rs_wa = sl_r; rs_wd = rs_rd - f_r;
        fl_we = 1'b1; fl_wa = sl_r[SLOT_W-1:1];
        fl_wd = sl_r[0] ? (fl_rd - f_r) : (fl_rd + f_r);
        rs_ra = sl_r ^ SLOT_W'(1);
        hd_ra = sl_r ^ SLOT_W'(1);
      end
      ST_AR: begin
        rs_we = 1'b1; rs_wa = sl_r ^ SLOT_W'(1); rs_wd = rs_rd + f_r;
        v_nxt = hd_rd;
      end
      // saturating total
      ST_ATOT: begin
        if (total_r > RESULT_MAX - RES_W'(f_r)) begin
          total_nxt = RESULT_MAX;
        end else begin
          total_nxt = total_r + RES_W'(f_r);
        end
      end
      default: begin
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vcount_r <= 8'd128;
      ecnt_r   <= '0;
      has_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ecnt_r  <= ecnt_nxt;
      has_r   <= has_nxt;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
      if (state_r == ST_DONE && out_free) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_r   <= in_vertex_a;
      b_r   <= in_vertex_b;
      cap_r <= in_capacity;
    end
    vis_r   <= vis_nxt;
    qh_r    <= qh_nxt;
    qt_r    <= qt_nxt;
    sl_r    <= sl_nxt;
    ulast_r <= ulast_nxt;
    ubot_r  <= ubot_nxt;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    f_r     <= f_nxt;
    v_r     <= v_nxt;
    total_r <= total_nxt;
    rval_r  <= rval_nxt;
    rst_r   <= rst_nxt;
    if (state_r == ST_DONE && out_free) begin
      oval_r <= (rst_r == STAT_OK) ? rval_r : '0;
      ost_r  <= rst_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_result_value = oval_r;
  assign out_status       = ost_r;

  // checks
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_result_value == '0)
    else $error("error result carries a value");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SL |-> 32'(qt_r) <= MAX_VERTICES)
    else $error("search queue overran");

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ecnt_r) <= MAX_EDGES)
    else $error("edge count overran");

endmodule
